[sv/sq16_pkg.sv]
// ----------------------------------------------------------------------------
// sq16_pkg: shared types and constants for the saturating Q16.16 ALU
// Opcodes, sequencer states, flag positions and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package sq16_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIV_BITS  = 32 + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_BITS);

    localparam logic [5:0]  MAX_SHIFT = 6'd62;
    localparam logic [63:0] DIV_MASK  = (64'd1 << DIV_BITS) - 64'd1;
    localparam logic [63:0] SAT_MAX   = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] SAT_MIN   = 64'hFFFF_FFFF_8000_0000;

    localparam int NUM_FLAGS = 4;
    localparam int FLAG_OVF  = 0;
    localparam int FLAG_UNF  = 1;
    localparam int FLAG_DIVZ = 2;
    localparam int FLAG_DOM  = 3;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL64 = 3'd2,
        OP_MULQ  = 3'd3,
        OP_DIVQ  = 3'd4,
        OP_SHIFT = 3'd5,
        OP_CLAMP = 3'd6,
        OP_CLEAR = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_PASS,
        ST_SHIFT,
        ST_ROUND,
        ST_DIV,
        ST_DIV_FIX
    } state_t;

    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
        logic        unf;
    } sat_t;

    // Clamps a signed 64-bit value to the signed 32-bit range.
    function automatic sat_t sat32(input logic [63:0] x);
        sat_t r;
        r.ovf = !x[63] && (x[62:31] != '0);
        r.unf = x[63] && (x[62:31] != '1);
        if (r.ovf)
        begin
            r.value = SAT_MAX;
        end
        else if (r.unf)
        begin
            r.value = SAT_MIN;
        end
        else
        begin
            r.value = x;
        end
        return r;
    endfunction

endpackage

[sv/saturating_q16_alu.sv]
// ----------------------------------------------------------------------------
// saturating_q16_alu: fixed-point ALU with sticky fault flags
// One shared 64-bit adder under a small sequencer serves add, subtract,
// rounding, restoring division steps and the final sign fix.
// ----------------------------------------------------------------------------
// States: none for clear and divide by zero; ADD for add and subtract; SHIFT
// for clamp and out-of-range shift; SHIFT, ROUND for round shift; MUL, PASS
// for 64-bit product; MUL, SHIFT, ROUND for Q16.16 multiply; DIV (one quotient
// bit per cycle), DIV_FIX for Q16.16 divide. busy stays high until done is
// shown, so one item is in work at a time. The receiver cannot stall: done is
// high for a single cycle. Reset clears the sequencer, the strobe and flags.
module saturating_q16_alu
    import sq16_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         op,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    input  logic signed [63:0] wide_value,
    input  logic [5:0]         shift_amount,
    output logic               done,
    output logic signed [63:0] result,
    output logic               overflow_flag,
    output logic               underflow_flag,
    output logic               div_zero_flag,
    output logic               domain_flag,
    output logic               any_fault
);

    state_t                 state_reg, state_next;
    logic                   done_reg, done_next;
    logic [NUM_FLAGS-1:0]   flags_reg, flags_next;

    op_t                    op_reg, op_next;
    logic signed [31:0]     a_reg, a_next;
    logic signed [31:0]     b_reg, b_next;
    logic signed [63:0]     acc_reg, acc_next;
    logic [5:0]             shamt_reg, shamt_next;
    logic                   inc_reg, inc_next;
    logic [31:0]            dvs_reg, dvs_next;
    logic [31:0]            rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [63:0]     result_reg, result_next;

    logic [63:0]            add_x, add_y, add_sum;
    logic                   add_sub;
    logic [32:0]            trial;
    logic signed [63:0]     product;
    logic signed [63:0]     shifted;
    logic [5:0]             shamt_m1;
    logic                   guard, sticky;
    logic [31:0]            mag_a, mag_b;
    sat_t                   sat_res;

    assign trial    = {rem_reg, acc_reg[DIV_BITS-1]};
    assign product  = a_reg * b_reg;
    assign shifted  = acc_reg >>> shamt_reg;
    assign shamt_m1 = shamt_reg - 6'd1;
    assign guard    = acc_reg[shamt_m1];
    assign sticky   = |(acc_reg & ~({64{1'b1}} << shamt_m1));
    assign mag_a    = operand_a[31] ? (~operand_a + 32'd1) : operand_a;
    assign mag_b    = operand_b[31] ? (~operand_b + 32'd1) : operand_b;

    // Operand selection for the shared adder.
    always_comb
    begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_ADD:
            begin
                add_x   = {{32{a_reg[31]}}, a_reg};
                add_y   = {{32{b_reg[31]}}, b_reg};
                add_sub = (op_reg == OP_SUB);
            end
            ST_ROUND:
            begin
                add_x = acc_reg;
                add_y = {63'd0, inc_reg};
            end
            ST_DIV:
            begin
                add_x   = {31'd0, trial};
                add_y   = {32'd0, dvs_reg};
                add_sub = 1'b1;
            end
            ST_DIV_FIX:
            begin
                add_y   = acc_reg;
                add_sub = neg_reg;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    assign add_sum = add_x + (add_y ^ {64{add_sub}}) + {63'd0, add_sub};

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        flags_next  = flags_reg;
        op_next     = op_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        acc_next    = acc_reg;
        shamt_next  = shamt_reg;
        inc_next    = inc_reg;
        dvs_next    = dvs_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        sat_res     = sat32((state_reg == ST_SHIFT) ? acc_reg : add_sum);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = op_t'(op);
                    a_next     = operand_a;
                    b_next     = operand_b;
                    acc_next   = wide_value;
                    shamt_next = shift_amount;
                    case (op_t'(op))
                        OP_ADD, OP_SUB:
                        begin
                            state_next = ST_ADD;
                        end
                        OP_MUL64, OP_MULQ:
                        begin
                            state_next = ST_MUL;
                        end
                        OP_DIVQ:
                        begin
                            if (operand_b == 32'sd0)
                            begin
                                result_next          = '0;
                                flags_next[FLAG_DIVZ] = 1'b1;
                                done_next            = 1'b1;
                            end
                            else
                            begin
                                acc_next   = $signed(64'({mag_a, {FRAC_BITS{1'b0}}}));
                                dvs_next   = mag_b;
                                neg_next   = operand_a[31] ^ operand_b[31];
                                rem_next   = '0;
                                cnt_next   = CNT_W'(DIV_BITS - 1);
                                state_next = ST_DIV;
                            end
                        end
                        OP_SHIFT:
                        begin
                            state_next = ST_SHIFT;
                        end
                        OP_CLAMP:
                        begin
                            // A clamp is a shift by zero.
                            shamt_next = '0;
                            state_next = ST_SHIFT;
                        end
                        OP_CLEAR:
                        begin
                            flags_next  = '0;
                            result_next = '0;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ADD, ST_ROUND, ST_DIV_FIX:
            begin
                result_next          = sat_res.value;
                flags_next[FLAG_OVF] = flags_reg[FLAG_OVF] | sat_res.ovf;
                flags_next[FLAG_UNF] = flags_reg[FLAG_UNF] | sat_res.unf;
                done_next            = 1'b1;
                state_next           = ST_IDLE;
            end
            ST_MUL:
            begin
                acc_next   = product;
                shamt_next = 6'(FRAC_BITS);
                state_next = (op_reg == OP_MUL64) ? ST_PASS : ST_SHIFT;
            end
            ST_PASS:
            begin
                result_next = acc_reg;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_SHIFT:
            begin
                if (shamt_reg > MAX_SHIFT)
                begin
                    result_next          = '0;
                    flags_next[FLAG_DOM] = 1'b1;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
                else if (shamt_reg == 6'd0)
                begin
                    result_next          = sat_res.value;
                    flags_next[FLAG_OVF] = flags_reg[FLAG_OVF] | sat_res.ovf;
                    flags_next[FLAG_UNF] = flags_reg[FLAG_UNF] | sat_res.unf;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    // Round half to even: up when above half, or at half with an odd shifted value.
                    acc_next   = shifted;
                    inc_next   = guard & (sticky | shifted[0]);
                    state_next = ST_ROUND;
                end
            end
            ST_DIV:
            begin
                if (!add_sum[63])
                begin
                    rem_next = add_sum[31:0];
                end
                else
                begin
                    rem_next = trial[31:0];
                end
                acc_next = ((acc_reg << 1) | {63'd0, !add_sum[63]}) & DIV_MASK;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_DIV_FIX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        shamt_reg  <= shamt_next;
        inc_reg    <= inc_next;
        dvs_reg    <= dvs_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign result         = result_reg;
    assign overflow_flag  = flags_reg[FLAG_OVF];
    assign underflow_flag = flags_reg[FLAG_UNF];
    assign div_zero_flag  = flags_reg[FLAG_DIVZ];
    assign domain_flag    = flags_reg[FLAG_DOM];
    assign any_fault      = |flags_reg;

    // A result is only shown once the sequencer is back at rest.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("done while busy");

    // Add and subtract go through the adder state and report done in the cycle after it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == OP_ADD || op == OP_SUB)) |=> busy ##1 done)
        else $error("add or subtract latency wrong");

    // A clear reports no faults at all.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_CLEAR) |=> done && !any_fault && result == '0)
        else $error("clear left a flag or a value");

    // Every result except the full product lies in the 32-bit range.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && op_reg != OP_MUL64) |-> (result[63:31] == '0 || result[63:31] == '1))
        else $error("result outside 32-bit range");

    // Sticky flags only change when a result is reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(flags_reg) |-> done)
        else $error("flags changed without a result");

endmodule
